FILE: rtl/msd_pkg.sv
// Shared widths and types of the mean and standard deviation block.
package msd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int SUM_W     = 40;
    localparam int SQSUM_W   = 64;
    localparam int OUT_W     = 40;
    localparam int FRAC_W    = 16;
    localparam int ALU_W     = 128;
    localparam int ROOT_W    = 57;
    localparam int REM_W     = ROOT_W + 2;
    localparam int RAD_TOP   = 2 * ROOT_W - 1;
    localparam int RAD_SHIFT = 2 * FRAC_W;
    localparam int VAR_W     = 2 * ROOT_W - RAD_SHIFT;
    localparam int ITER_W    = 6;
    localparam int TDATA_W   = 2 * OUT_W;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [SQSUM_W-1:0] sq_sum;
        logic               dropped;
    } msd_snap_t;

    typedef struct packed {
        logic [OUT_W-1:0] mean;
        logic [OUT_W-1:0] std_dev;
        logic             overflow;
    } msd_result_t;

endpackage

FILE: rtl/msd_alu.sv
// Shared wide adder and subtractor with a carry out for comparisons.
module msd_alu (
    input  logic [msd_pkg::ALU_W-1:0] a,
    input  logic [msd_pkg::ALU_W-1:0] b,
    input  logic                      sub,
    output logic [msd_pkg::ALU_W-1:0] res,
    output logic                      carry
);
    import msd_pkg::*;

    logic [ALU_W:0] total;

    // When subtracting, the carry out is set exactly when a >= b.
    assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
    assign res   = total[ALU_W-1:0];
    assign carry = total[ALU_W];

endmodule

FILE: rtl/msd_acc.sv
// Sample accumulator: count, sum and a pipelined sum of squares.
module msd_acc #(
    parameter int MAX_SAMPLES = 65536,
    parameter int CNT_W       = 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [msd_pkg::SAMPLE_W-1:0] sample,
    input  logic                         last,
    output logic                         pipe_last,
    output logic                         start,
    output logic [CNT_W-1:0]             count,
    output msd_pkg::msd_snap_t           snap
);
    import msd_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic                p1_valid_reg;
    logic                p1_last_reg;
    logic [SAMPLE_W-1:0] p1_sample_reg;
    logic                p2_valid_reg;
    logic                p2_last_reg;
    logic [SQ_W-1:0]     p2_square_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQSUM_W-1:0]  sq_sum_reg, sq_sum_next, sq_sum_add;
    logic                drop_reg, drop_next;
    logic                room;

    assign room       = (count_reg < MAX_CNT);
    assign sq_sum_add = sq_sum_reg + (p2_valid_reg ? SQSUM_W'(p2_square_reg) : '0);

    always_comb
    begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        sq_sum_next = sq_sum_add;
        drop_next   = drop_reg;
        if (accept)
        begin
            if (room)
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg + SUM_W'(sample);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
        // The set is handed to the sequencer as its last square lands, so clear for the next.
        if (p2_last_reg)
        begin
            count_next  = '0;
            sum_next    = '0;
            sq_sum_next = '0;
            drop_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept && room;
            p1_last_reg  <= accept && last;
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            sq_sum_reg   <= sq_sum_next;
            drop_reg     <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_sample_reg <= sample;
        p2_square_reg <= p1_sample_reg * p1_sample_reg;
    end

    assign pipe_last   = p1_last_reg | p2_last_reg;
    assign start       = p2_last_reg;
    assign count       = count_reg;
    assign snap.sum    = sum_reg;
    assign snap.sq_sum = sq_sum_add;
    assign snap.dropped = drop_reg;

    a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        p2_last_reg |=> (count_reg == '0 && sum_reg == '0 && sq_sum_reg == '0 && !drop_reg))
        else $error("accumulators not cleared after a set was handed over");

    a_count_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("sample count beyond capacity");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_reg == MAX_CNT) |=> drop_reg)
        else $error("sample at full capacity not flagged as dropped");

endmodule

FILE: rtl/msd_seq.sv
// Sequencer that runs the divisions, products and square root on the shared unit.
module msd_seq #(
    parameter int CNT_W = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CNT_W-1:0]     count,
    input  msd_pkg::msd_snap_t   snap,
    input  logic                 done_ack,
    output logic                 idle,
    output logic                 done_valid,
    output msd_pkg::msd_result_t result
);
    import msd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MEAN = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_MUL2 = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DEV  = 7'b0100000,
        S_DONE = 7'b1000000
    } msd_state_t;

    msd_state_t         state_reg, state_next;
    logic [ITER_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ALU_W-1:0]   mcand_reg, mcand_next;
    logic [SUM_W-1:0]   mplier_reg, mplier_next;
    logic [ALU_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  div_reg, div_next;
    logic [OUT_W-1:0]   mean_reg, mean_next;
    logic               drop_reg, drop_next;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
    logic               alu_sub, alu_carry;
    logic [CNT_W:0]     div_trial;
    logic [REM_W-1:0]   sq_trial_rem, sq_trial_sub;
    logic [ROOT_W-1:0]  quo_step;

    // Division brings down one dividend bit; the root takes two radicand bits a step.
    assign div_trial    = {rem_reg[CNT_W-1:0], div_reg[ROOT_W-1]};
    assign sq_trial_rem = {rem_reg[ROOT_W-1:0], mcand_reg[RAD_TOP -: 2]};
    assign sq_trial_sub = {div_reg, 2'b01};
    assign quo_step     = {div_reg[ROOT_W-2:0], alu_carry};

    always_comb
    begin
        unique case (state_reg) inside
            S_MEAN, S_DEV:
            begin
                alu_a   = ALU_W'(div_trial);
                alu_b   = ALU_W'(n_reg);
                alu_sub = 1'b1;
            end
            S_MUL1, S_MUL2:
            begin
                alu_a   = acc_reg;
                alu_b   = mplier_reg[0] ? mcand_reg : '0;
                alu_sub = (state_reg == S_MUL2);
            end
            S_SQRT:
            begin
                alu_a   = ALU_W'(sq_trial_rem);
                alu_b   = ALU_W'(sq_trial_sub);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    msd_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        sum_next    = sum_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        mean_next   = mean_reg;
        drop_next   = drop_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = (count == '0) ? CNT_W'(1) : count;
                    sum_next   = snap.sum;
                    mcand_next = ALU_W'(snap.sq_sum);
                    drop_next  = snap.dropped;
                    div_next   = ROOT_W'({snap.sum, FRAC_W'(0)});
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = ITER_W'(ROOT_W - 1);
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                div_next = quo_step;
                rem_next = REM_W'(alu_carry ? alu_res[CNT_W:0] : div_trial);
                cnt_next = cnt_reg - ITER_W'(1);
                if (cnt_reg == '0)
                begin
                    mean_next   = quo_step[OUT_W-1:0];
                    mplier_next = SUM_W'(n_reg);
                    cnt_next    = ITER_W'(CNT_W - 1);
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                acc_next    = alu_res;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - ITER_W'(1);
                if (cnt_reg == '0)
                begin
                    mcand_next  = ALU_W'(sum_reg);
                    mplier_next = sum_reg;
                    cnt_next    = ITER_W'(SUM_W - 1);
                    state_next  = S_MUL2;
                end
            end
            S_MUL2:
            begin
                acc_next    = alu_res;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - ITER_W'(1);
                if (cnt_reg == '0)
                begin
                    // The radicand is the variance term scaled by 2^32.
                    mcand_next = {alu_res[ALU_W-RAD_SHIFT-1:0], RAD_SHIFT'(0)};
                    rem_next   = '0;
                    div_next   = '0;
                    cnt_next   = ITER_W'(ROOT_W - 1);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                div_next   = quo_step;
                rem_next   = alu_carry ? alu_res[REM_W-1:0] : sq_trial_rem;
                mcand_next = mcand_reg << 2;
                cnt_next   = cnt_reg - ITER_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = ITER_W'(ROOT_W - 1);
                    state_next = S_DEV;
                end
            end
            S_DEV:
            begin
                div_next = quo_step;
                rem_next = REM_W'(alu_carry ? alu_res[CNT_W:0] : div_trial);
                cnt_next = cnt_reg - ITER_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        sum_reg    <= sum_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        mean_reg   <= mean_next;
        drop_reg   <= drop_next;
    end

    assign idle            = (state_reg == S_IDLE);
    assign done_valid      = (state_reg == S_DONE);
    assign result.mean     = mean_reg;
    assign result.std_dev  = div_reg[OUT_W-1:0];
    assign result.overflow = drop_reg;

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg != '0))
        else $error("sequencer busy with a zero sample count");

    a_variance_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (acc_reg[ALU_W-1:VAR_W] == '0))
        else $error("variance term out of range before the square root");

    a_deviation_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (div_reg[ROOT_W-1:OUT_W] == '0))
        else $error("deviation quotient exceeds the output width");

endmodule

FILE: rtl/mean_and_std_deviation_core.sv
// A sample without last is added into the accumulators; after a last sample, the set runs
// through the mean division, the products, the square root and the deviation division.
// Throughput: one sample per cycle; after a last sample, tready stays low until the
// sequencer is idle again, after the serial passes on the shared adder and the output hand-off.
// Reset: rst_n clears the accumulators, the sequencer state and the output valid flag at once.
module mean_and_std_deviation_core #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [msd_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [23:0] sample
    input  logic                        s_axis_tlast,   // last
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [msd_pkg::TDATA_W-1:0] m_axis_tdata,   // [39:0] mean, [79:40] std_dev
    output logic                        m_axis_tuser    // [0] overflow
);
    import msd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    logic             accept;
    logic             pipe_last;
    logic             start;
    logic [CNT_W-1:0] count;
    msd_snap_t        snap;
    logic             seq_idle;
    logic             done_valid;
    logic             done_ack;
    msd_result_t      seq_result;

    logic             out_valid_reg, out_valid_next;
    msd_result_t      out_result_reg;

    // A request is refused while a last sample is in flight or the sequencer is busy.
    assign s_axis_tready = seq_idle & ~pipe_last;
    assign accept        = s_axis_tvalid & s_axis_tready;

    msd_acc #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (s_axis_tdata),
        .last      (s_axis_tlast),
        .pipe_last (pipe_last),
        .start     (start),
        .count     (count),
        .snap      (snap)
    );

    msd_seq #(
        .CNT_W (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .count      (count),
        .snap       (snap),
        .done_ack   (done_ack),
        .idle       (seq_idle),
        .done_valid (done_valid),
        .result     (seq_result)
    );

    assign done_ack = done_valid & (~out_valid_reg | m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ack)
        begin
            out_result_reg <= seq_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.std_dev, out_result_reg.mean};
    assign m_axis_tuser  = out_result_reg.overflow;

endmodule
